// File: design/arns_pkg.sv
// Package for the angular radius neighbor search unit: payload structs, codes,
// fixed-point widths and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arns_pkg;

  localparam int ARNS_MAX_POINTS = 64;
  localparam int COORD_W         = 16;
  localparam int COORD_FRAC_BITS = 14;
  localparam int IDX_W           = 6;
  localparam int NUM_POINTS_W    = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int PROD_W          = 2 * COORD_W;
  localparam int DOT_W           = PROD_W + 2;
  localparam int THR_PAD_W       = DOT_W - COORD_W - COORD_FRAC_BITS;

  localparam logic signed [DOT_W-1:0] DOT_ONE = DOT_W'(1) << (2 * COORD_FRAC_BITS);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS    = 1'b1;

  localparam logic signed [COORD_W-1:0] COS_THRESHOLD_RST = 16'sd16384;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                      func;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbor_index;
    logic             found;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } dot_feed_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } dot_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// File: design/arns_cell.sv
// One storage cell of the point ring: holds one point, loads it from the input
// beat or takes its neighbor's point on a shift. Depends on arns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arns_cell
  import arns_pkg::*;
(
  input  wire    clk,
  input  wire    load_en,
  input  point_t load_pt,
  input  wire    shift_en,
  input  point_t shift_pt,
  output point_t pt
);

  point_t pt_q;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pt_q <= load_pt;
    end else if (shift_en) begin
      pt_q <= shift_pt;
    end
  end

  assign pt = pt_q;

endmodule

`default_nettype wire

// File: design/arns_dot.sv
// Two-stage dot product and threshold compare for the ring head point.
// Depends on arns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arns_dot
  import arns_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       en,
  input  dot_feed_t                 feed,
  input  point_t                    qpt,
  input  point_t                    cpt,
  input  wire signed [COORD_W-1:0]  thr,
  output dot_res_t                  res
);

  logic signed [PROD_W-1:0] p_x;
  logic signed [PROD_W-1:0] p_y;
  logic signed [PROD_W-1:0] p_z;
  dot_feed_t                s1;
  dot_res_t                 s2;

  logic signed [DOT_W-1:0]  sum;
  logic signed [DOT_W-1:0]  clamped;
  logic signed [DOT_W-1:0]  thr_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      p_x <= qpt.x * cpt.x;
      p_y <= qpt.y * cpt.y;
      p_z <= qpt.z * cpt.z;
    end
  end

  always_comb begin
    sum = DOT_W'(p_x) + DOT_W'(p_y) + DOT_W'(p_z);
    if (sum < -DOT_ONE) begin
      clamped = -DOT_ONE;
    end else if (sum > DOT_ONE) begin
      clamped = DOT_ONE;
    end else begin
      clamped = sum;
    end
    thr_ext = $signed({{THR_PAD_W{thr[COORD_W-1]}}, thr, {COORD_FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= feed.valid;
      s2.valid <= s1.valid;
    end
    if (en) begin
      s1.idx <= feed.idx;
      s2.idx <= s1.idx;
      s2.hit <= clamped > thr_ext;
    end
  end

  assign res = s2;

endmodule

`default_nettype wire

// File: design/angular_radius_neighbor_search_unit.sv
// Top level of the angular radius neighbor search unit: ring of point cells,
// dot product stage, sequencer and output register. Depends on arns_pkg,
// arns_cell and arns_dot.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item (in_item_t)
//   out      output     out_valid / out_stall out_item (out_item_t)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load writes the addressed cell on its beat. On a query the point ring
// makes one full turn to fetch the queried point and a second turn that
// feeds one point a cycle, while the output is not stalled, to the dot
// product stage; ST_DRAIN1 and ST_DRAIN2 drain it, ST_FLUSH emits the final result.
// Reset is synchronous; the point ring keeps no reset and needs no clearing.
// A stalled output beat freezes the ring and the dot product stage.
`timescale 1ns / 1ps
`default_nettype none

module angular_radius_neighbor_search_unit
  import arns_pkg::*;
#(
  parameter int MAX_POINTS = ARNS_MAX_POINTS
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  wire                   out_stall,
  output out_item_t             out_item,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = $clog2(MAX_POINTS);

  state_t                     state;
  state_t                     state_next;
  logic [POS_W-1:0]           pos;
  logic [IDX_W-1:0]           qidx;
  point_t                     qpt;
  logic signed [COORD_W-1:0]  thr;
  logic [NUM_POINTS_W-1:0]    np;
  logic [NUM_POINTS_W-1:0]    limit;
  logic                       pend_valid;
  logic [IDX_W-1:0]           pend_idx;

  logic                       adv;
  logic                       pos_end;
  logic                       in_accept;
  logic                       is_load;
  logic                       idx_in_range;
  logic                       shift_en;
  logic                       fetch_hit;
  logic                       out_load;
  out_item_t                  out_next;
  dot_feed_t                  feed;
  dot_res_t                   dres;
  point_t                     load_pt;
  point_t                     cell_pt [MAX_POINTS];

  assign adv          = !out_valid || !out_stall;
  assign pos_end      = pos == POS_W'(MAX_POINTS - 1);
  assign in_accept    = in_valid && !in_stall;
  assign is_load      = in_item.func == FUNC_LOAD;
  assign idx_in_range = {1'b0, in_item.point_index} < NUM_POINTS_W'(MAX_POINTS);
  assign limit        = (np > NUM_POINTS_W'(MAX_POINTS)) ? NUM_POINTS_W'(MAX_POINTS) : np;
  assign cfg_ready    = 1'b1;
  assign load_pt      = '{x: in_item.coord_x, y: in_item.coord_y, z: in_item.coord_z};

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    arns_cell u_cell (
      .clk      (clk),
      .load_en  (in_accept && is_load && (in_item.point_index == IDX_W'(k))),
      .load_pt  (load_pt),
      .shift_en (shift_en),
      .shift_pt (cell_pt[(k + 1) % MAX_POINTS]),
      .pt       (cell_pt[k])
    );
  end

  arns_dot u_dot (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .feed (feed),
    .qpt  (qpt),
    .cpt  (cell_pt[0]),
    .thr  (thr),
    .res  (dres)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && !is_load && idx_in_range) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (adv && pos_end) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv && pos_end) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        if (adv) begin
          state_next = ST_DRAIN2;
        end
      end
      ST_DRAIN2: begin
        if (adv) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = !((state == ST_IDLE) && adv);
    shift_en   = adv && ((state == ST_FETCH) || (state == ST_SCAN));
    fetch_hit  = (state == ST_FETCH) && (IDX_W'(pos) == qidx);
    feed.valid = (state == ST_SCAN) && (NUM_POINTS_W'(pos) < limit);
    feed.idx   = IDX_W'(pos);
    out_load   = 1'b0;
    out_next   = '{neighbor_index: '0, found: 1'b0, last: 1'b1};
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          out_load = is_load || !idx_in_range;
          if (is_load) begin
            out_next.neighbor_index = in_item.point_index;
          end
        end
      end
      ST_FLUSH: begin
        out_load = 1'b1;
        if (pend_valid) begin
          out_next = '{neighbor_index: pend_idx, found: 1'b1, last: 1'b1};
        end
      end
      default: begin
        if (dres.valid && dres.hit && pend_valid) begin
          out_load = 1'b1;
          out_next = '{neighbor_index: pend_idx, found: 1'b1, last: 1'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      thr        <= COS_THRESHOLD_RST;
      np         <= '0;
    end else begin
      state <= state_next;
      if (shift_en) begin
        pos <= pos_end ? '0 : pos + POS_W'(1);
      end
      if (adv) begin
        out_valid <= out_load;
        if (state == ST_FLUSH) begin
          pend_valid <= 1'b0;
        end else if (dres.valid && dres.hit) begin
          pend_valid <= 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COS_THRESHOLD: thr <= $signed(cfg_data[COORD_W-1:0]);
          CFG_NUM_POINTS:    np  <= cfg_data[NUM_POINTS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      qidx <= in_item.point_index;
    end
    if (adv && fetch_hit) begin
      qpt <= cell_pt[0];
    end
    if (adv && dres.valid && dres.hit) begin
      pend_idx <= dres.idx;
    end
    if (adv) begin
      out_item <= out_next;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending result left over in idle");

  a_idle_ring_home: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pos == '0))
    else $error("point ring not at home position in idle");

  a_mid_hit_has_next: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.found && !out_item.last) |-> pend_valid)
    else $error("non-final neighbor beat without a following result");

  a_dot_res_in_scan: assert property (@(posedge clk) disable iff (rst)
    dres.valid |-> ((state == ST_SCAN) || (state == ST_DRAIN1) || (state == ST_DRAIN2)))
    else $error("dot product result outside the scan");

endmodule

`default_nettype wire
